FILE: rtl/scpm_pkg.sv
// Package for the servo command priority mux: widths, codes, states and the
// calibration reset word. No dependencies.
`default_nettype none
package scpm_pkg;
   localparam int NumSlotsDefault    = 8;
   localparam int NumRunstopsDefault = 8;
   localparam int AgeBitsDefault     = 16;
   localparam int CalW   = 44;
   localparam int ValW   = 16;
   localparam int PulseW = 14;
   localparam int SrcW   = 4;

   localparam logic [1:0] CMD_COMMANDER = 2'd0;
   localparam logic [1:0] CMD_RUNSTOP   = 2'd1;
   localparam logic [1:0] CMD_TICK      = 2'd2;

   localparam logic [2:0] REG_CMD_AGE  = 3'd0;
   localparam logic [2:0] REG_RS_AGE   = 3'd1;
   localparam logic [2:0] REG_THR_CAL  = 3'd2;
   localparam logic [2:0] REG_STR_CAL  = 3'd3;
   localparam logic [2:0] REG_BRK_CAL  = 3'd4;

   localparam logic [SrcW-1:0] SRC_NONE = 4'd8;
   localparam logic [SrcW-1:0] SRC_STOP = 4'd9;

   localparam logic [15:0]     AGE_LIMIT_RESET = 16'd50;
   localparam logic [CalW-1:0] CAL_RESET       = 44'd9332980319708;
   localparam logic signed [ValW-1:0] ONE_Q14  = 16'sd16384;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_PULSE_T, ST_PULSE_S, ST_PULSE_B, ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       write_cmd;
      logic       write_rs;
      logic       scan_start;
      logic       scan_step;
      logic [1:0] pulse_sel;
      logic       pulse_go;
      logic       age_all;
      logic       emit;
   } ctl_type;

   // Status from the datapath.
   typedef struct packed {
      logic scan_last;
   } stat_type;
endpackage
`default_nettype wire

FILE: rtl/scpm_ctrl.sv
// Sequencer for the servo command priority mux. Walks a tick through the
// slot scan and three pulse multiplies. Depends on scpm_pkg.
`default_nettype none
module scpm_ctrl import scpm_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [1:0] req_cmd,
   input  wire stat_type   stat,
   output logic            busy,
   output ctl_type         ctl
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.write_cmd = (req_cmd == CMD_COMMANDER);
               ctl.write_rs  = (req_cmd == CMD_RUNSTOP);
               if (req_cmd == CMD_TICK) begin
                  ctl.scan_start = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ctl.scan_step = 1'b1;
            if (stat.scan_last) state_in = ST_PULSE_T;
         end
         ST_PULSE_T: begin
            ctl.pulse_go = 1'b1; ctl.pulse_sel = 2'd0; state_in = ST_PULSE_S;
         end
         ST_PULSE_S: begin
            ctl.pulse_go = 1'b1; ctl.pulse_sel = 2'd1; state_in = ST_PULSE_B;
         end
         ST_PULSE_B: begin
            ctl.pulse_go = 1'b1; ctl.pulse_sel = 2'd2; state_in = ST_DONE;
         end
         ST_DONE: begin
            ctl.emit = 1'b1;
            ctl.age_all = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/scpm_datapath.sv
// Datapath for the servo command priority mux: slot and runstop stores,
// priority scan over cycles, shared pulse multiplier. Depends on scpm_pkg.
`default_nettype none
module scpm_datapath import scpm_pkg::*; #(
   parameter int NUM_SLOTS    = NumSlotsDefault,
   parameter int NUM_RUNSTOPS = NumRunstopsDefault,
   parameter int AGE_BITS     = AgeBitsDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctl_type                ctl,
   output stat_type                    stat,
   input  wire logic [2:0]             req_slot,
   input  wire logic signed [ValW-1:0] req_throttle_in,
   input  wire logic signed [ValW-1:0] req_steering_in,
   input  wire logic signed [ValW-1:0] req_brake_in,
   input  wire logic                   req_motion_ok_in,
   input  wire logic                   csr_we,
   input  wire logic [2:0]             csr_index,
   input  wire logic [CalW-1:0]        csr_data,
   output logic                        rsp_motion_enabled,
   output logic [SrcW-1:0]             rsp_throttle_source,
   output logic signed [ValW-1:0]      rsp_throttle_value,
   output logic [PulseW-1:0]           rsp_throttle_pulse,
   output logic [SrcW-1:0]             rsp_steering_source,
   output logic signed [ValW-1:0]      rsp_steering_value,
   output logic [PulseW-1:0]           rsp_steering_pulse,
   output logic [SrcW-1:0]             rsp_brake_source,
   output logic [ValW-2:0]             rsp_brake_value,
   output logic [PulseW-1:0]           rsp_brake_pulse
);
   localparam int SlotIdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int RsIdxW   = (NUM_RUNSTOPS > 1) ? $clog2(NUM_RUNSTOPS) : 1;
   localparam logic [AGE_BITS-1:0] AgeMax = '1;

   logic [15:0]     cmd_age_lim_ff, rs_age_lim_ff;
   logic [CalW-1:0] cal_ff [3];

   logic signed [ValW-1:0] thr_ff [NUM_SLOTS];
   logic signed [ValW-1:0] str_ff [NUM_SLOTS];
   logic signed [ValW-1:0] brk_ff [NUM_SLOTS];
   logic [AGE_BITS-1:0]    sage_ff [NUM_SLOTS];
   logic [NUM_RUNSTOPS-1:0] seen_ff, en_ff;
   logic [AGE_BITS-1:0]    rage_ff [NUM_RUNSTOPS];

   logic [SlotIdxW-1:0] idx_ff;
   logic motion_ff;
   logic t_found_ff, s_found_ff, b_found_ff;
   logic [SrcW-1:0] tsrc_ff, ssrc_ff, bsrc_ff;
   logic signed [ValW-1:0] tval_ff, sval_ff, bval_ff;
   logic [PulseW-1:0] tp_ff, sp_ff, bp_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_age_lim_ff <= AGE_LIMIT_RESET;
         rs_age_lim_ff  <= AGE_LIMIT_RESET;
         for (int k = 0; k < 3; k++) cal_ff[k] <= CAL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CMD_AGE: cmd_age_lim_ff <= csr_data[15:0];
            REG_RS_AGE:  rs_age_lim_ff  <= csr_data[15:0];
            REG_THR_CAL: cal_ff[0] <= csr_data;
            REG_STR_CAL: cal_ff[1] <= csr_data;
            REG_BRK_CAL: cal_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Runstop evaluation is a narrow reduction over the source bits.
   logic [NUM_RUNSTOPS-1:0] rs_stop;
   always_comb begin
      for (int r = 0; r < NUM_RUNSTOPS; r++)
         rs_stop[r] = seen_ff[r] && !en_ff[r] &&
                      (32'(rage_ff[r]) < 32'(rs_age_lim_ff));
   end
   wire any_stop = |rs_stop;
   wire motion_now = (|seen_ff) && !any_stop;

   // Current scan slot.
   wire signed [ValW-1:0] cur_t = thr_ff[idx_ff];
   wire signed [ValW-1:0] cur_s = str_ff[idx_ff];
   wire signed [ValW-1:0] cur_b = brk_ff[idx_ff];
   wire cur_fresh = (32'(sage_ff[idx_ff]) < 32'(cmd_age_lim_ff));
   wire t_ok = cur_fresh && cur_t <= ONE_Q14 && cur_t >= -ONE_Q14;
   wire s_ok = cur_fresh && cur_s <= ONE_Q14 && cur_s >= -ONE_Q14;
   wire b_ok = cur_fresh && cur_b <= ONE_Q14 && cur_b >= 0;
   wire [SrcW-1:0] cur_src = SrcW'(idx_ff);

   assign stat.scan_last = (idx_ff == SlotIdxW'(NUM_SLOTS - 1));

   // Pulse unit: one multiply per cycle, shared across channels.
   logic [CalW-1:0] pcal;
   logic signed [ValW-1:0] pval;
   logic pdrive;
   always_comb begin
      unique case (ctl.pulse_sel)
         2'd0: begin pcal = cal_ff[0]; pval = tval_ff; pdrive = t_found_ff; end
         2'd1: begin pcal = cal_ff[1]; pval = sval_ff; pdrive = s_found_ff; end
         default: begin pcal = cal_ff[2]; pval = bval_ff; pdrive = b_found_ff; end
      endcase
   end
   logic signed [16:0] p;
   logic signed [15:0] span;
   logic signed [33:0] prod;
   logic signed [35:0] num;
   logic [PulseW-1:0]  pulse;
   always_comb begin
      p = pcal[42] ? -{pval[15], pval} : {pval[15], pval};
      if (p > 0) span = $signed({2'b00, pcal[41:28]}) - $signed({2'b00, pcal[13:0]});
      else       span = $signed({2'b00, pcal[13:0]}) - $signed({2'b00, pcal[27:14]});
      prod = p * span;
      num = $signed({6'd0, pcal[13:0], 16'd0}) + (36'(prod) <<< 2);
      if (!pcal[43] || !pdrive || num < 0) pulse = '0;
      else if (num[35:14] > 22'd16383) pulse = '1;
      else pulse = num[27:14];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            thr_ff[k] <= '0; str_ff[k] <= '0; brk_ff[k] <= '0; sage_ff[k] <= AgeMax;
         end
         seen_ff <= '0;
         en_ff   <= '0;
         for (int k = 0; k < NUM_RUNSTOPS; k++) rage_ff[k] <= AgeMax;
      end else begin
         if (ctl.write_cmd && 32'(req_slot) < NUM_SLOTS) begin
            thr_ff[req_slot[SlotIdxW-1:0]]  <= req_throttle_in;
            str_ff[req_slot[SlotIdxW-1:0]]  <= req_steering_in;
            brk_ff[req_slot[SlotIdxW-1:0]]  <= req_brake_in;
            sage_ff[req_slot[SlotIdxW-1:0]] <= '0;
         end
         if (ctl.write_rs && 32'(req_slot) < NUM_RUNSTOPS) begin
            seen_ff[req_slot[RsIdxW-1:0]] <= 1'b1;
            en_ff[req_slot[RsIdxW-1:0]]   <= req_motion_ok_in;
            rage_ff[req_slot[RsIdxW-1:0]] <= '0;
         end
         if (ctl.age_all) begin
            for (int k = 0; k < NUM_SLOTS; k++)
               if (sage_ff[k] != AgeMax) sage_ff[k] <= sage_ff[k] + 1'b1;
            for (int k = 0; k < NUM_RUNSTOPS; k++)
               if (rage_ff[k] != AgeMax) rage_ff[k] <= rage_ff[k] + 1'b1;
         end
      end
   end

   // Scan and pulse result registers.
   always_ff @(posedge clock) begin
      if (ctl.scan_start) begin
         idx_ff <= '0;
         motion_ff <= motion_now;
         t_found_ff <= 1'b0; s_found_ff <= 1'b0; b_found_ff <= 1'b0;
         tsrc_ff <= any_stop ? SRC_STOP : SRC_NONE;
         ssrc_ff <= SRC_NONE; bsrc_ff <= SRC_NONE;
         tval_ff <= '0; sval_ff <= '0; bval_ff <= '0;
      end else if (ctl.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (!t_found_ff && motion_ff && t_ok) begin
            t_found_ff <= 1'b1; tsrc_ff <= cur_src; tval_ff <= cur_t;
         end
         if (!s_found_ff && s_ok) begin
            s_found_ff <= 1'b1; ssrc_ff <= cur_src; sval_ff <= cur_s;
         end
         if (!b_found_ff && b_ok) begin
            b_found_ff <= 1'b1; bsrc_ff <= cur_src; bval_ff <= cur_b;
         end
      end
      if (ctl.pulse_go) begin
         unique case (ctl.pulse_sel)
            2'd0: tp_ff <= pulse;
            2'd1: sp_ff <= pulse;
            default: bp_ff <= pulse;
         endcase
      end
   end

   assign rsp_motion_enabled  = motion_ff;
   assign rsp_throttle_source = tsrc_ff;
   assign rsp_throttle_value  = tval_ff;
   assign rsp_throttle_pulse  = tp_ff;
   assign rsp_steering_source = ssrc_ff;
   assign rsp_steering_value  = sval_ff;
   assign rsp_steering_pulse  = sp_ff;
   assign rsp_brake_source    = bsrc_ff;
   assign rsp_brake_value     = bval_ff[ValW-2:0];
   assign rsp_brake_pulse     = bp_ff;
endmodule
`default_nettype wire

FILE: rtl/servo_command_priority_mux_core.sv
// Top level of the servo command priority mux: sequencer plus datapath.
// Depends on scpm_pkg, scpm_ctrl and scpm_datapath.
//
//   channel   handshake              word carried
//   req_      start / busy           cmd, slot, three Q2.14 values, motion bit
//   rsp_      rsp_valid strobe       motion flag, source/value/pulse per servo
//   csr_      csr_valid / csr_ready  register index and data
//
// An update is stored on the edge that accepts it. A tick latches the runstop
// verdict, scans the slots in turn for the priority winners, runs three pulse
// multiplies on the shared multiplier, and ends with rsp_valid high for a
// single cycle. The stores reset at once; there is no clearing pass. The
// receiver cannot stall, and configuration is accepted every cycle.
`default_nettype none
module servo_command_priority_mux_core import scpm_pkg::*; #(
   parameter int NUM_SLOTS    = NumSlotsDefault,
   parameter int NUM_RUNSTOPS = NumRunstopsDefault,
   parameter int AGE_BITS     = AgeBitsDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [1:0]             req_cmd,
   input  wire logic [2:0]             req_slot,
   input  wire logic signed [ValW-1:0] req_throttle_in,
   input  wire logic signed [ValW-1:0] req_steering_in,
   input  wire logic signed [ValW-1:0] req_brake_in,
   input  wire logic                   req_motion_ok_in,
   output logic                        rsp_valid,
   output logic                        rsp_motion_enabled,
   output logic [SrcW-1:0]             rsp_throttle_source,
   output logic signed [ValW-1:0]      rsp_throttle_value,
   output logic [PulseW-1:0]           rsp_throttle_pulse,
   output logic [SrcW-1:0]             rsp_steering_source,
   output logic signed [ValW-1:0]      rsp_steering_value,
   output logic [PulseW-1:0]           rsp_steering_pulse,
   output logic [SrcW-1:0]             rsp_brake_source,
   output logic [ValW-2:0]             rsp_brake_value,
   output logic [PulseW-1:0]           rsp_brake_pulse,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [2:0]             csr_index,
   input  wire logic [CalW-1:0]        csr_data
);
   ctl_type  ctl;
   stat_type stat;

   // Registers can be written at any time; the host is bound to write only when idle, and the block leaves this to it.
   assign csr_ready = 1'b1;
   assign rsp_valid = ctl.emit;

   scpm_ctrl u_ctrl (
      .clock, .reset, .start, .req_cmd, .stat, .busy, .ctl
   );

   scpm_datapath #(
      .NUM_SLOTS(NUM_SLOTS), .NUM_RUNSTOPS(NUM_RUNSTOPS), .AGE_BITS(AGE_BITS)
   ) u_dp (
      .clock, .reset, .ctl, .stat,
      .req_slot, .req_throttle_in, .req_steering_in, .req_brake_in, .req_motion_ok_in,
      .csr_we(csr_valid && csr_ready), .csr_index, .csr_data,
      .rsp_motion_enabled, .rsp_throttle_source, .rsp_throttle_value,
      .rsp_throttle_pulse, .rsp_steering_source, .rsp_steering_value,
      .rsp_steering_pulse, .rsp_brake_source, .rsp_brake_value, .rsp_brake_pulse
   );
endmodule
`default_nettype wire

FILE: rtl/scpm_checker.sv
// Port-level checks for the servo command priority mux, bound to the top.
// Depends on scpm_pkg.
`default_nettype none
module scpm_checker import scpm_pkg::*; (
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            start,
   input wire logic            busy,
   input wire logic [1:0]      req_cmd,
   input wire logic            rsp_valid,
   input wire logic            rsp_motion_enabled,
   input wire logic [SrcW-1:0] rsp_throttle_source,
   input wire logic [PulseW-1:0] rsp_throttle_pulse
);
   // A result appears only at the end of a busy tick.
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a tick");
   // An accepted tick makes the block busy.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_TICK) |=> busy) else $error("tick not taken");
   // Blocked throttle means motion is off and no pulse.
   a_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_throttle_source == SRC_STOP) |->
      (!rsp_motion_enabled && rsp_throttle_pulse == '0)) else $error("stop leak");
   // Results are single-cycle strobes.
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("strobe too long");
endmodule

bind servo_command_priority_mux_core scpm_checker u_chk (
   .clock, .reset, .start, .busy, .req_cmd, .rsp_valid,
   .rsp_motion_enabled, .rsp_throttle_source, .rsp_throttle_pulse
);
`default_nettype wire

FILE: bench/scpm_checker.sv
// Scoreboard for the servo command priority mux: it watches the request, result and
// register channels and predicts every tick word. It depends on scpm_pkg only.
`default_nettype none
module scpm_scoreboard import scpm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   busy,
   input  wire logic [1:0]             req_cmd,
   input  wire logic [2:0]             req_slot,
   input  wire logic signed [ValW-1:0] req_throttle_in,
   input  wire logic signed [ValW-1:0] req_steering_in,
   input  wire logic signed [ValW-1:0] req_brake_in,
   input  wire logic                   req_motion_ok_in,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_motion_enabled,
   input  wire logic [SrcW-1:0]        rsp_throttle_source,
   input  wire logic signed [ValW-1:0] rsp_throttle_value,
   input  wire logic [PulseW-1:0]      rsp_throttle_pulse,
   input  wire logic [SrcW-1:0]        rsp_steering_source,
   input  wire logic signed [ValW-1:0] rsp_steering_value,
   input  wire logic [PulseW-1:0]      rsp_steering_pulse,
   input  wire logic [SrcW-1:0]        rsp_brake_source,
   input  wire logic [ValW-2:0]        rsp_brake_value,
   input  wire logic [PulseW-1:0]      rsp_brake_pulse,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [2:0]             csr_index,
   input  wire logic [CalW-1:0]        csr_data,
   output int                          failures,
   output int                          pending
);
   localparam int Slots    = NumSlotsDefault;
   localparam int Runstops = NumRunstopsDefault;
   localparam int WordDepth = 4;
   localparam logic [15:0] AgeTop = 16'hFFFF;

   typedef struct packed {
      logic              motion;
      logic [SrcW-1:0]   t_src;
      logic [ValW-1:0]   t_val;
      logic [PulseW-1:0] t_pulse;
      logic [SrcW-1:0]   s_src;
      logic [ValW-1:0]   s_val;
      logic [PulseW-1:0] s_pulse;
      logic [SrcW-1:0]   b_src;
      logic [ValW-2:0]   b_val;
      logic [PulseW-1:0] b_pulse;
   } servo_word_type;

   logic [15:0]     cmd_age_limit, rs_age_limit;
   logic [CalW-1:0] cal_thr, cal_str, cal_brk;
   int              cmd_thr [Slots];
   int              cmd_str [Slots];
   int              cmd_brk [Slots];
   logic [15:0]     cmd_age [Slots];
   logic            rs_seen [Runstops];
   logic            rs_on   [Runstops];
   logic [15:0]     rs_age  [Runstops];

   // Expected words wait in a small ring; the block holds at most one tick.
   servo_word_type  expected_words [WordDepth];
   logic [1:0]      head_ptr, tail_ptr;
   int              word_count = 0;

   assign pending = word_count;

   function automatic logic [PulseW-1:0] servo_pulse(logic [CalW-1:0] cal, int value);
      longint center, lo, hi, p, num;
      center = longint'(cal[13:0]);
      lo     = longint'(cal[27:14]);
      hi     = longint'(cal[41:28]);
      p      = value;
      if (!cal[43]) return '0;
      if (cal[42]) p = -p;
      num = center * 65536;
      if (p > 0) num += 4 * p * (hi - center);
      else if (p < 0) num += 4 * p * (center - lo);
      if (num < 0) return '0;
      num = num / 16384;
      if (num > 16383) num = 16383;
      return num[PulseW-1:0];
   endfunction

   // Evaluate one tick against the current stores, then age everything.
   function automatic servo_word_type evaluate_tick();
      servo_word_type w;
      logic any_seen, stopped, motion;
      int   tsrc, ssrc, bsrc, tval, sval, bval;
      any_seen = 1'b0;
      stopped  = 1'b0;
      tsrc = 8; ssrc = 8; bsrc = 8;
      tval = 0; sval = 0; bval = 0;
      for (int i = 0; i < Runstops; i++) begin
         if (rs_seen[i]) begin
            any_seen = 1'b1;
            if (rs_age[i] < rs_age_limit && !rs_on[i]) stopped = 1'b1;
         end
      end
      motion = any_seen && !stopped;
      if (stopped) tsrc = 9;
      for (int i = 0; i < Slots; i++) begin
         if (cmd_age[i] < cmd_age_limit) begin
            if (tsrc == 8 && motion && cmd_thr[i] <= 16384 && cmd_thr[i] >= -16384) begin
               tsrc = i; tval = cmd_thr[i];
            end
            if (ssrc == 8 && cmd_str[i] <= 16384 && cmd_str[i] >= -16384) begin
               ssrc = i; sval = cmd_str[i];
            end
            if (bsrc == 8 && cmd_brk[i] <= 16384 && cmd_brk[i] >= 0) begin
               bsrc = i; bval = cmd_brk[i];
            end
         end
      end
      w.motion  = motion;
      w.t_src   = tsrc[SrcW-1:0];
      w.t_val   = tval[ValW-1:0];
      w.t_pulse = (tsrc < 8) ? servo_pulse(cal_thr, tval) : '0;
      w.s_src   = ssrc[SrcW-1:0];
      w.s_val   = sval[ValW-1:0];
      w.s_pulse = (ssrc < 8) ? servo_pulse(cal_str, sval) : '0;
      w.b_src   = bsrc[SrcW-1:0];
      w.b_val   = bval[ValW-2:0];
      w.b_pulse = (bsrc < 8) ? servo_pulse(cal_brk, bval) : '0;
      for (int i = 0; i < Slots; i++) if (cmd_age[i] != AgeTop) cmd_age[i]++;
      for (int i = 0; i < Runstops; i++) if (rs_age[i] != AgeTop) rs_age[i]++;
      return w;
   endfunction

   always @(posedge clock) begin
      servo_word_type w;
      int errs;
      errs = 0;
      if (reset) begin
         failures      <= 0;
         cmd_age_limit = AGE_LIMIT_RESET;
         rs_age_limit  = AGE_LIMIT_RESET;
         cal_thr = CAL_RESET; cal_str = CAL_RESET; cal_brk = CAL_RESET;
         for (int i = 0; i < Slots; i++) begin
            cmd_thr[i] = 0; cmd_str[i] = 0; cmd_brk[i] = 0; cmd_age[i] = AgeTop;
         end
         for (int i = 0; i < Runstops; i++) begin
            rs_seen[i] = 1'b0; rs_on[i] = 1'b0; rs_age[i] = AgeTop;
         end
         head_ptr   = '0;
         tail_ptr   = '0;
         word_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CMD_AGE: cmd_age_limit = csr_data[15:0];
               REG_RS_AGE:  rs_age_limit  = csr_data[15:0];
               REG_THR_CAL: cal_thr = csr_data;
               REG_STR_CAL: cal_str = csr_data;
               REG_BRK_CAL: cal_brk = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (word_count == 0) begin
               $error("result word with no tick waiting");
               errs++;
            end else begin
               w = expected_words[head_ptr];
               head_ptr = head_ptr + 2'd1;
               word_count--;
               if (rsp_motion_enabled !== w.motion ||
                   rsp_throttle_source !== w.t_src || rsp_throttle_value !== w.t_val ||
                   rsp_throttle_pulse !== w.t_pulse ||
                   rsp_steering_source !== w.s_src || rsp_steering_value !== w.s_val ||
                   rsp_steering_pulse !== w.s_pulse ||
                   rsp_brake_source !== w.b_src || rsp_brake_value !== w.b_val ||
                   rsp_brake_pulse !== w.b_pulse)
                  errs++;
               if (rsp_motion_enabled !== w.motion)
                  $error("motion_enabled expected %0d got %0d", w.motion, rsp_motion_enabled);
               if (rsp_throttle_source !== w.t_src)
                  $error("throttle_source expected %0d got %0d", w.t_src, rsp_throttle_source);
               if (rsp_throttle_value !== w.t_val)
                  $error("throttle_value expected %0d got %0d", $signed(w.t_val),
                         rsp_throttle_value);
               if (rsp_throttle_pulse !== w.t_pulse)
                  $error("throttle_pulse expected %0d got %0d", w.t_pulse, rsp_throttle_pulse);
               if (rsp_steering_source !== w.s_src)
                  $error("steering_source expected %0d got %0d", w.s_src, rsp_steering_source);
               if (rsp_steering_value !== w.s_val)
                  $error("steering_value expected %0d got %0d", $signed(w.s_val),
                         rsp_steering_value);
               if (rsp_steering_pulse !== w.s_pulse)
                  $error("steering_pulse expected %0d got %0d", w.s_pulse, rsp_steering_pulse);
               if (rsp_brake_source !== w.b_src)
                  $error("brake_source expected %0d got %0d", w.b_src, rsp_brake_source);
               if (rsp_brake_value !== w.b_val)
                  $error("brake_value expected %0d got %0d", w.b_val, rsp_brake_value);
               if (rsp_brake_pulse !== w.b_pulse)
                  $error("brake_pulse expected %0d got %0d", w.b_pulse, rsp_brake_pulse);
            end
         end
         if (start && !busy) begin
            case (req_cmd)
               CMD_COMMANDER: begin
                  cmd_thr[req_slot] = req_throttle_in;
                  cmd_str[req_slot] = req_steering_in;
                  cmd_brk[req_slot] = req_brake_in;
                  cmd_age[req_slot] = '0;
               end
               CMD_RUNSTOP: begin
                  rs_seen[req_slot] = 1'b1;
                  rs_on[req_slot]   = req_motion_ok_in;
                  rs_age[req_slot]  = '0;
               end
               CMD_TICK: begin
                  if (word_count == WordDepth) begin
                     $error("tick accepted with %0d results still owed", word_count);
                     errs++;
                  end else begin
                     expected_words[tail_ptr] = evaluate_tick();
                     tail_ptr = tail_ptr + 2'd1;
                     word_count++;
                  end
               end
               default: ;
            endcase
         end
         failures <= failures + errs;
      end
   end
endmodule
`default_nettype wire

FILE: bench/tb_servo_command_priority_mux_core.sv
// Top of the servo command priority mux bench: clock, reset, request and register
// stimulus, and the verdict. Depends on scpm_pkg, scpm_scoreboard and the block itself.
`default_nettype none
module tb_servo_command_priority_mux_core import scpm_pkg::*;;
   // The fourth command code is unused; the block must swallow it without a word.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // Far above the slowest legal run: 750 random words, the directed ones and idle gaps.
   localparam int CycleLimit = 400000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic [1:0]             req_cmd = '0;
   logic [2:0]             req_slot = '0;
   logic signed [ValW-1:0] req_throttle_in = '0;
   logic signed [ValW-1:0] req_steering_in = '0;
   logic signed [ValW-1:0] req_brake_in = '0;
   logic                   req_motion_ok_in = 1'b0;
   logic                   csr_valid = 1'b0;
   logic [2:0]             csr_index = '0;
   logic [CalW-1:0]        csr_data = '0;

   logic                   busy, rsp_valid, rsp_motion_enabled, csr_ready;
   logic [SrcW-1:0]        rsp_throttle_source, rsp_steering_source, rsp_brake_source;
   logic signed [ValW-1:0] rsp_throttle_value, rsp_steering_value;
   logic [ValW-2:0]        rsp_brake_value;
   logic [PulseW-1:0]      rsp_throttle_pulse, rsp_steering_pulse, rsp_brake_pulse;

   int failures, pending, cycle_count = 0, idle_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   servo_command_priority_mux_core dut (.*);
   scpm_scoreboard u_scoreboard (.*);

   // A hung handshake must still end the run with a verdict.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offer one request word and return on the edge that accepts it. Start stays
   // high on return; words keep it high between them unless idle_pct draws a gap.
   task automatic send_word(logic [1:0] cmd, logic [2:0] slot, logic [15:0] thr,
                            logic [15:0] str, logic [15:0] brk, logic ok);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start            <= 1'b1;
      req_cmd          <= cmd;
      req_slot         <= slot;
      req_throttle_in  <= thr;
      req_steering_in  <= str;
      req_brake_in     <= brk;
      req_motion_ok_in <= ok;
      do @(posedge clock); while (busy);
   endtask

   // Drain all outstanding ticks, then give the block time to finish any update.
   task automatic drain();
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [CalW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CalW-1:0] random_cal();
      logic [CalW-1:0] c;
      c = CalW'({$urandom, $urandom});
      c[43] = ($urandom_range(9) != 0);
      return c;
   endfunction

   // Mostly legal Q2.14 values, with extremes and out-of-range words mixed in.
   function automatic logic [15:0] random_value(logic unipolar);
      case ($urandom_range(9))
         0: return ($urandom_range(1)) ? 16'sd16384 : (unipolar ? 16'sd0 : -16'sd16384);
         1: return 16'($urandom);
         default: return unipolar ? 16'($urandom_range(16384))
                                  : 16'($urandom_range(32768) - 16384);
      endcase
   endfunction

   task automatic program_phase(int phase);
      case (phase)
         0: begin
            write_reg(REG_CMD_AGE, 44'd5);
            write_reg(REG_RS_AGE, 44'd8);
            write_reg(REG_THR_CAL, random_cal());
            write_reg(REG_STR_CAL, random_cal());
            write_reg(REG_BRK_CAL, random_cal());
         end
         1: begin
            write_reg(REG_CMD_AGE, 44'd65535);
            write_reg(REG_RS_AGE, 44'd65535);
            write_reg(REG_THR_CAL, '0);
            write_reg(REG_STR_CAL, '1);
            write_reg(REG_BRK_CAL, CAL_RESET | (44'd1 << 42));
         end
         2: begin
            write_reg(REG_CMD_AGE, 44'd1);
            write_reg(REG_RS_AGE, 44'd1);
            write_reg(REG_THR_CAL, random_cal());
            write_reg(REG_STR_CAL, CAL_RESET & ~(44'd1 << 43));
            write_reg(REG_BRK_CAL, random_cal());
         end
         3: begin
            write_reg(REG_CMD_AGE, 44'($urandom_range(2, 30)));
            write_reg(REG_RS_AGE, 44'($urandom_range(2, 30)));
            write_reg(REG_THR_CAL, random_cal());
            write_reg(REG_STR_CAL, random_cal());
            write_reg(REG_BRK_CAL, random_cal());
         end
         default: begin
            write_reg(REG_CMD_AGE, 44'(AGE_LIMIT_RESET));
            write_reg(REG_RS_AGE, 44'(AGE_LIMIT_RESET));
            write_reg(REG_THR_CAL, CAL_RESET);
            write_reg(REG_STR_CAL, CAL_RESET);
            write_reg(REG_BRK_CAL, CAL_RESET);
         end
      endcase
   endtask

   initial begin
      int pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at reset settings. No runstop seen yet, so throttle has
      // no winner even with fresh commanders.
      send_word(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_word(CMD_COMMANDER, 3'd0, 16'sd16384, -16'sd16384, 16'sd16384, 1'b0);
      send_word(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_word(CMD_RUNSTOP, 3'd7, 16'd0, 16'd0, 16'd0, 1'b1);
      send_word(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      // Out-of-range values in the top slot fall through to the lower one.
      send_word(CMD_COMMANDER, 3'd0, 16'sd16385, 16'h8000, -16'sd1, 1'b1);
      send_word(CMD_COMMANDER, 3'd7, -16'sd16384, 16'sd16384, 16'sd0, 1'b1);
      send_word(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_word(CMD_COMMANDER, 3'd3, 16'h7FFF, -16'sd16385, 16'sd16385, 1'b0);
      send_word(CMD_UNUSED, 3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_word(CMD_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      // A fresh stop blocks throttle only.
      send_word(CMD_RUNSTOP, 3'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_word(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_word(CMD_RUNSTOP, 3'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      send_word(CMD_COMMANDER, 3'd1, 16'sd8192, -16'sd8192, 16'sd4096, 1'b0);
      send_word(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      drain();

      // Random phases, each under new register settings written while idle.
      for (int phase = 0; phase < 5; phase++) begin
         program_phase(phase);
         case (phase)
            1: idle_pct = 72;
            3: idle_pct = 11;
            4: idle_pct = 72;
            default: idle_pct = 0;
         endcase
         for (int n = 0; n < 150; n++) begin
            pick = $urandom_range(99);
            if (pick < 35)
               send_word(CMD_COMMANDER, 3'($urandom), random_value(1'b0),
                         random_value(1'b0), random_value(1'($urandom_range(1))),
                         1'($urandom));
            else if (pick < 50)
               send_word(CMD_RUNSTOP, 3'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), ($urandom_range(3) != 0));
            else if (pick < 95)
               send_word(CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 1'($urandom));
            else
               send_word(CMD_UNUSED, 3'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 1'($urandom));
         end
         drain();
      end

      if (failures == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
